[design/motor_command_frame_builder_core_assert.svh]
// Assertion macros shared by the frame builder modules.
// Each macro expects aclk and aresetn in the scope where it is used.
`ifndef MOTOR_COMMAND_FRAME_BUILDER_CORE_ASSERT_SVH
`define MOTOR_COMMAND_FRAME_BUILDER_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define MCFB_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define MCFB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/mcfb_pkg.sv]
`timescale 1ns / 1ps

package mcfb_pkg;

    // Build-time limits
    localparam int MAX_DATA_BYTES_DEF = 4;
    localparam int SIZE_W             = 4;   // holds a clamped size up to 8
    localparam int POS_W              = 5;   // frame byte positions 0..22 at the default limit
    localparam int CFG_IDX_W          = 2;
    localparam int CFG_DATA_W         = 16;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_NODE_ADDRESS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COB_ID        = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_ADDRESS = 2'd2;

    // Register reset values
    localparam logic [7:0]  NODE_ADDRESS_RST  = 8'h05;
    localparam logic [7:0]  COB_ID_RST        = 8'h01;
    localparam logic [15:0] START_ADDRESS_RST = 16'h0000;

    // Fixed frame bytes
    localparam logic [7:0] HDR0_BYTE  = 8'h4E;
    localparam logic [7:0] HDR1_BYTE  = 8'h54;
    localparam logic [7:0] XFER0_BYTE = 8'h2B;
    localparam logic [7:0] XFER1_BYTE = 8'h0D;
    localparam logic [7:0] ZERO_BYTE  = 8'h00;
    localparam logic [7:0] LEN_FIXED  = 8'd15;

    // CRC-16/Modbus
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // Frame layout: header and length, inner message, data, CRC
    localparam logic [POS_W-1:0] POS_INNER   = 5'd4;
    localparam logic [POS_W-1:0] POS_DATA    = 5'd17;
    localparam logic [POS_W-1:0] POS_LAST_FX = 5'd18;  // last position for size 0

    // Controller to datapath commands
    typedef struct packed {
        logic             capture;
        logic             load;
        logic [POS_W-1:0] pos;
    } dp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic [POS_W-1:0] last_pos;
    } dp_stat_t;

    // Fold one byte into the reflected CRC, one bit per step
    function automatic logic [15:0] crc16_update(input logic [15:0] crc_in,
                                                 input logic [7:0]  data_in);
        logic [15:0] crc;
        crc = crc_in ^ {8'h00, data_in};
        for (int k = 0; k < 8; k++) begin
            if (crc[0]) begin
                crc = (crc >> 1) ^ CRC_POLY;
            end else begin
                crc = crc >> 1;
            end
        end
        return crc;
    endfunction

endpackage

[design/motor_command_frame_builder_core.sv]
`timescale 1ns / 1ps
// Channel   | Direction | tdata (low bit up)                               | tuser  | tlast
// s_axis    | in        | object_index, sub_index, data_size, data_value   | action | -
// m_axis    | out       | frame_byte                                       | -      | last_byte
// cfg       | in        | write enable, index, 16-bit data                 | -      | -
//
// A command is accepted, then its frame goes out through the output register,
// one frame byte per cycle while the output does not stall.
// The CRC folds one byte per cycle as each inner byte is loaded.
// Reset (aresetn, synchronous, active low) clears the controller and restores
// the configuration registers. Output stalls hold the current byte and pause the frame.

module motor_command_frame_builder_core #(
    parameter int MAX_DATA_BYTES = mcfb_pkg::MAX_DATA_BYTES_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [63:0]                       s_axis_tdata,  // object_index, sub_index, data_size, data_value
    input  logic                              s_axis_tuser,  // action
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [7:0]                        m_axis_tdata,  // frame_byte
    output logic                              m_axis_tlast,
    input  logic                              cfg_wen,
    input  logic [mcfb_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [mcfb_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    mcfb_pkg::dp_cmd_t  cmd;
    mcfb_pkg::dp_stat_t stat;

    mcfb_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .m_valid (m_axis_tvalid),
        .m_ready (m_axis_tready),
        .cmd     (cmd),
        .stat    (stat)
    );

    mcfb_dp #(
        .MAX_DATA_BYTES (MAX_DATA_BYTES)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wen      (cfg_wen),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .action       (s_axis_tuser),
        .object_index (s_axis_tdata[15:0]),
        .sub_index    (s_axis_tdata[23:16]),
        .data_size    (s_axis_tdata[26:24]),
        .data_value   (s_axis_tdata[58:27]),
        .cmd          (cmd),
        .stat         (stat),
        .frame_byte   (m_axis_tdata),
        .last_byte    (m_axis_tlast)
    );

endmodule

[design/mcfb_ctrl.sv]
`timescale 1ns / 1ps
`include "motor_command_frame_builder_core_assert.svh"

module mcfb_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    output mcfb_pkg::dp_cmd_t   cmd,
    input  mcfb_pkg::dp_stat_t  stat
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SEND = 1'b1;

    logic                      state_reg, state_next;
    logic [mcfb_pkg::POS_W-1:0] pos_reg, pos_next;
    logic                      out_valid_reg, out_valid_next;
    logic                      accept;
    logic                      load;

    // Take a command only between frames
    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    // Load a byte when the output register is free or being drained
    assign load = (state_reg == ST_SEND) && (!out_valid_reg || m_ready);

    always_comb begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        out_valid_next = out_valid_reg;
        if (m_ready) begin
            out_valid_next = 1'b0;
        end
        if (load) begin
            out_valid_next = 1'b1;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_SEND;
                    pos_next   = '0;
                end
            end
            ST_SEND: begin
                if (load) begin
                    pos_next = pos_reg + 1'b1;
                    if (pos_reg == stat.last_pos) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_valid     = out_valid_reg;
    assign cmd.capture = accept;
    assign cmd.load    = load;
    assign cmd.pos     = pos_reg;

    `MCFB_ASSERT_NEXT(a_accept_starts_frame, accept, (state_reg == ST_SEND) && (pos_reg == '0), "accepted command did not start a frame at the first byte")
    `MCFB_ASSERT_NEXT(a_last_load_ends_frame, load && (pos_reg == stat.last_pos), state_reg == ST_IDLE, "frame did not end after its last byte")
    `MCFB_ASSERT_IMPLY(a_pos_in_frame, state_reg == ST_SEND, pos_reg <= stat.last_pos, "byte position ran past the frame end")
    `MCFB_ASSERT_NEXT(a_load_shows_byte, load, out_valid_reg, "loaded byte not presented")

endmodule

[design/mcfb_dp.sv]
`timescale 1ns / 1ps
`include "motor_command_frame_builder_core_assert.svh"

module mcfb_dp #(
    parameter int MAX_DATA_BYTES = mcfb_pkg::MAX_DATA_BYTES_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wen,
    input  logic [mcfb_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [mcfb_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic                               action,
    input  logic [15:0]                        object_index,
    input  logic [7:0]                         sub_index,
    input  logic [2:0]                         data_size,
    input  logic [31:0]                        data_value,
    input  mcfb_pkg::dp_cmd_t                  cmd,
    output mcfb_pkg::dp_stat_t                 stat,
    output logic [7:0]                         frame_byte,
    output logic                               last_byte
);

    localparam logic [mcfb_pkg::SIZE_W-1:0] MaxSize = mcfb_pkg::SIZE_W'(MAX_DATA_BYTES);

    logic [7:0]                   node_address_reg;
    logic [7:0]                   cob_id_reg;
    logic [15:0]                  start_address_reg;
    logic                         action_reg;
    logic [15:0]                  object_index_reg;
    logic [7:0]                   sub_index_reg;
    logic [mcfb_pkg::SIZE_W-1:0]  size_reg;
    logic [31:0]                  data_reg;
    logic [15:0]                  crc_reg, crc_next;
    logic [7:0]                   byte_reg;
    logic                         last_reg;
    logic [mcfb_pkg::SIZE_W-1:0]  size_in;
    logic [mcfb_pkg::SIZE_W-1:0]  size_clamped;
    logic [mcfb_pkg::POS_W-1:0]   data_end;
    logic [mcfb_pkg::POS_W-1:0]   data_idx;
    logic [31:0]                  data_shifted;
    logic [7:0]                   byte_sel;
    logic                         is_inner;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_address_reg  <= mcfb_pkg::NODE_ADDRESS_RST;
            cob_id_reg        <= mcfb_pkg::COB_ID_RST;
            start_address_reg <= mcfb_pkg::START_ADDRESS_RST;
        end else if (cfg_wen) begin
            unique case (cfg_index)
                mcfb_pkg::CFG_NODE_ADDRESS:  node_address_reg  <= cfg_wdata[7:0];
                mcfb_pkg::CFG_COB_ID:        cob_id_reg        <= cfg_wdata[7:0];
                mcfb_pkg::CFG_START_ADDRESS: start_address_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Clamp the requested size
    assign size_in      = {1'b0, data_size};
    assign size_clamped = (size_in > MaxSize) ? MaxSize : size_in;

    // Capture the command fields
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            action_reg       <= action;
            object_index_reg <= object_index;
            sub_index_reg    <= sub_index;
            size_reg         <= size_clamped;
            data_reg         <= data_value;
        end
    end

    assign data_end      = mcfb_pkg::POS_DATA + mcfb_pkg::POS_W'(size_reg);
    assign stat.last_pos = mcfb_pkg::POS_LAST_FX + mcfb_pkg::POS_W'(size_reg);
    assign data_idx      = cmd.pos - mcfb_pkg::POS_DATA;
    assign data_shifted  = data_reg >> {data_idx[1:0], 3'b000};
    assign is_inner      = (cmd.pos >= mcfb_pkg::POS_INNER) && (cmd.pos < data_end);

    // Select the frame byte for the current position
    always_comb begin
        unique case (cmd.pos)
            5'd0:    byte_sel = mcfb_pkg::HDR0_BYTE;
            5'd1:    byte_sel = mcfb_pkg::HDR1_BYTE;
            5'd2:    byte_sel = mcfb_pkg::ZERO_BYTE;
            5'd3:    byte_sel = mcfb_pkg::LEN_FIXED + 8'(size_reg);
            5'd4:    byte_sel = node_address_reg;
            5'd5:    byte_sel = mcfb_pkg::XFER0_BYTE;
            5'd6:    byte_sel = mcfb_pkg::XFER1_BYTE;
            5'd7:    byte_sel = {7'd0, action_reg};
            5'd8:    byte_sel = mcfb_pkg::ZERO_BYTE;
            5'd9:    byte_sel = cob_id_reg;
            5'd10:   byte_sel = object_index_reg[15:8];
            5'd11:   byte_sel = object_index_reg[7:0];
            5'd12:   byte_sel = sub_index_reg;
            5'd13:   byte_sel = start_address_reg[15:8];
            5'd14:   byte_sel = start_address_reg[7:0];
            5'd15:   byte_sel = mcfb_pkg::ZERO_BYTE;
            5'd16:   byte_sel = 8'(size_reg);
            default: begin
                if (cmd.pos < data_end) begin
                    // data bytes past the 32-bit value are zero
                    byte_sel = (data_idx[mcfb_pkg::POS_W-1:2] == '0) ?
                               data_shifted[7:0] : mcfb_pkg::ZERO_BYTE;
                end else if (cmd.pos == data_end) begin
                    byte_sel = crc_reg[7:0];
                end else begin
                    byte_sel = crc_reg[15:8];
                end
            end
        endcase
    end

    // Run the CRC over inner bytes as they leave
    always_comb begin
        crc_next = crc_reg;
        if (cmd.capture) begin
            crc_next = mcfb_pkg::CRC_INIT;
        end else if (cmd.load && is_inner) begin
            crc_next = mcfb_pkg::crc16_update(crc_reg, byte_sel);
        end
    end

    always_ff @(posedge aclk) begin
        crc_reg <= crc_next;
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            byte_reg <= byte_sel;
            last_reg <= (cmd.pos == stat.last_pos);
        end
    end

    assign frame_byte = byte_reg;
    assign last_byte  = last_reg;

    `MCFB_ASSERT_NEXT(a_capture_inits_crc, cmd.capture, crc_reg == mcfb_pkg::CRC_INIT, "CRC not initialized on a new command")
    `MCFB_ASSERT_NEXT(a_size_clamped, cmd.capture, size_reg <= MaxSize, "stored size exceeds the data byte limit")

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;
    import mcfb_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 6;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int DRAIN_CYCLES  = 40;
    localparam int SETTLE_CYCLES = 4;
    localparam int HOLDOFF_LEN   = 400;
    localparam int REPORT_LIMIT  = 10;
    localparam int SIZE_CLAMP    = 4;
    localparam int RANDOM_ITEMS  = 145;

    // Register index that maps to no register
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;

    localparam logic ACTION_READ  = 1'b0;
    localparam logic ACTION_WRITE = 1'b1;

    typedef struct {
        logic        action;
        logic [15:0] object_index;
        logic [7:0]  sub_index;
        logic [2:0]  data_size;
        logic [31:0] data_value;
    } command_t;

    typedef struct {
        logic [7:0] frame_byte;
        logic       last_byte;
    } frame_beat_t;

    logic                  aclk          = 1'b0;
    logic                  aresetn       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [63:0]           s_axis_tdata  = '0;
    logic                  s_axis_tuser  = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [7:0]            m_axis_tdata;
    logic                  m_axis_tlast;
    logic                  cfg_wen       = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index     = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata     = '0;

    // Shadow copy of the configuration registers
    logic [7:0]  node_address_sh  = NODE_ADDRESS_RST;
    logic [7:0]  cob_id_sh        = COB_ID_RST;
    logic [15:0] start_address_sh = START_ADDRESS_RST;

    frame_beat_t expected_frame_q[$];

    int send_gap_pct   = 0;
    int recv_idle_pct  = 0;
    int hold_left      = 0;
    logic hold_active  = 1'b0;
    int error_count    = 0;
    int commands_sent  = 0;
    int bytes_checked  = 0;
    int register_writes = 0;
    int cycle_count    = 0;

    motor_command_frame_builder_core i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_wen       (cfg_wen),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    always begin
        #CLK_HALF aclk = 1'b1;
        #CLK_HALF aclk = 1'b0;
    end

    // Fold one byte into the reflected CRC, data bit by data bit
    function automatic logic [15:0] crc_fold(input logic [15:0] crc_in,
                                             input logic [7:0] data_in);
        logic [15:0] crc;
        logic        feedback;
        crc = crc_in;
        for (int i = 0; i < 8; i++) begin
            feedback = crc[0] ^ data_in[i];
            crc = crc >> 1;
            if (feedback) begin
                crc = crc ^ CRC_POLY;
            end
        end
        return crc;
    endfunction

    function automatic logic [63:0] pack_command(input command_t cmd);
        return {5'b0, cmd.data_value, cmd.data_size, cmd.sub_index, cmd.object_index};
    endfunction

    function automatic command_t make_command(input logic action, input logic [15:0] obj,
                                              input logic [7:0] sub, input logic [2:0] size,
                                              input logic [31:0] value);
        command_t cmd;
        cmd.action       = action;
        cmd.object_index = obj;
        cmd.sub_index    = sub;
        cmd.data_size    = size;
        cmd.data_value   = value;
        return cmd;
    endfunction

    function automatic command_t random_command();
        command_t cmd;
        cmd.action       = 1'($urandom_range(1));
        cmd.object_index = 16'($urandom_range(16'hFFFF));
        cmd.sub_index    = 8'($urandom_range(8'hFF));
        cmd.data_value   = $urandom;
        // mostly legal sizes, some that clamp
        cmd.data_size = ($urandom_range(99) < 85) ? 3'($urandom_range(SIZE_CLAMP))
                                                  : 3'($urandom_range(7, SIZE_CLAMP + 1));
        if ($urandom_range(99) < 10) begin
            cmd.data_value = ($urandom_range(1) == 1) ? 32'hFFFF_FFFF : 32'h0000_0000;
        end
        return cmd;
    endfunction

    function automatic void push_beat(input logic [7:0] value, input logic last);
        frame_beat_t beat;
        beat.frame_byte = value;
        beat.last_byte  = last;
        expected_frame_q.push_back(beat);
    endfunction

    // Build the whole frame that one command should produce
    function automatic void predict_frame(input command_t cmd);
        logic [7:0]  inner [0:16];
        logic [15:0] crc;
        logic [7:0]  frame_len;
        int          n_data;
        int          n_inner;
        n_data = (cmd.data_size > SIZE_CLAMP) ? SIZE_CLAMP : int'(cmd.data_size);
        n_inner = 13 + n_data;
        frame_len = 8'(n_inner + 2);
        inner[0]  = node_address_sh;
        inner[1]  = XFER0_BYTE;
        inner[2]  = XFER1_BYTE;
        inner[3]  = {7'b0, cmd.action};
        inner[4]  = ZERO_BYTE;
        inner[5]  = cob_id_sh;
        inner[6]  = cmd.object_index[15:8];
        inner[7]  = cmd.object_index[7:0];
        inner[8]  = cmd.sub_index;
        inner[9]  = start_address_sh[15:8];
        inner[10] = start_address_sh[7:0];
        inner[11] = ZERO_BYTE;
        inner[12] = 8'(n_data);
        for (int i = 0; i < n_data; i++) begin
            inner[13 + i] = cmd.data_value[8 * i +: 8];
        end
        push_beat(HDR0_BYTE, 1'b0);
        push_beat(HDR1_BYTE, 1'b0);
        push_beat(ZERO_BYTE, 1'b0);
        push_beat(frame_len, 1'b0);
        crc = CRC_INIT;
        for (int i = 0; i < n_inner; i++) begin
            push_beat(inner[i], 1'b0);
            crc = crc_fold(crc, inner[i]);
        end
        push_beat(crc[7:0], 1'b0);
        push_beat(crc[15:8], 1'b1);
    endfunction

    function automatic void report_failure(input string msg);
        error_count++;
        if (error_count <= REPORT_LIMIT) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
    endfunction

    function automatic void check_frame_byte(input logic [7:0] got_byte, input logic got_last);
        frame_beat_t exp_beat;
        if (expected_frame_q.size() == 0) begin
            report_failure($sformatf("unexpected byte %02h last %0b", got_byte, got_last));
        end else begin
            exp_beat = expected_frame_q.pop_front();
            bytes_checked++;
            if (exp_beat.frame_byte !== got_byte) begin
                report_failure($sformatf("frame_byte expected %02h got %02h",
                                         exp_beat.frame_byte, got_byte));
            end
            if (exp_beat.last_byte !== got_last) begin
                report_failure($sformatf("last_byte expected %0b got %0b (byte %02h)",
                                         exp_beat.last_byte, got_last, got_byte));
            end
        end
    endfunction

    // Result side: check each transfer, then pick the next ready
    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            check_frame_byte(m_axis_tdata, m_axis_tlast);
        end
        if (hold_active) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Count down a long output hold-off
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            hold_active <= 1'b1;
            hold_left   <= hold_left - 1;
        end else begin
            hold_active <= 1'b0;
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d bytes outstanding",
                     cycle_count, expected_frame_q.size());
            $display("status: fail");
            $finish;
        end
    end

    // Offer one command, hold it until the transfer, then predict its frame
    task automatic send_command(input command_t cmd);
        while ($urandom_range(99) < send_gap_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pack_command(cmd);
        s_axis_tuser  <= cmd.action;
        do begin
            @(posedge aclk);
        end while (!s_axis_tready);
        predict_frame(cmd);
        commands_sent++;
    endtask

    // Drop valid and wait until every expected byte has come out
    task automatic drain_frames();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_frame_q.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wen <= 1'b0;
        @(posedge aclk);
        register_writes++;
        case (idx)
            CFG_NODE_ADDRESS:  node_address_sh  = value[7:0];
            CFG_COB_ID:        cob_id_sh        = value[7:0];
            CFG_START_ADDRESS: start_address_sh = value[15:0];
            default: ;
        endcase
    endtask

    task automatic set_idle_mix(input int send_pct, input int recv_pct);
        send_gap_pct  = send_pct;
        recv_idle_pct = recv_pct;
    endtask

    task automatic test_reset_values();
        send_command(make_command(ACTION_READ, 16'h6041, 8'h00, 3'd0, 32'h0));
        send_command(make_command(ACTION_WRITE, 16'h6040, 8'h00, 3'd2, 32'h0000_000F));
        send_command(make_command(ACTION_WRITE, 16'h607A, 8'h00, 3'd4, 32'h1234_5678));
        drain_frames();
    endtask

    task automatic test_field_extremes();
        send_command(make_command(ACTION_READ, 16'h0000, 8'h00, 3'd0, 32'h0000_0000));
        send_command(make_command(ACTION_WRITE, 16'hFFFF, 8'hFF, 3'd4, 32'hFFFF_FFFF));
        send_command(make_command(ACTION_READ, 16'hFFFF, 8'h00, 3'd1, 32'hFFFF_FF80));
        send_command(make_command(ACTION_WRITE, 16'h0000, 8'hFF, 3'd3, 32'hA5C3_5A3C));
        // negative values go out as raw two's complement bytes
        send_command(make_command(ACTION_WRITE, 16'h607A, 8'h00, 3'd4, 32'h8000_0000));
        send_command(make_command(ACTION_WRITE, 16'h607A, 8'h00, 3'd4, 32'h7FFF_FFFF));
        // sizes above the limit clamp to four bytes
        send_command(make_command(ACTION_WRITE, 16'h1234, 8'h56, 3'd5, 32'hDEAD_BEEF));
        send_command(make_command(ACTION_READ, 16'h4321, 8'h65, 3'd6, 32'h0102_0304));
        send_command(make_command(ACTION_WRITE, 16'hAAAA, 8'h55, 3'd7, 32'hFFFF_FFFF));
        // reads carry data whenever a size is given
        send_command(make_command(ACTION_READ, 16'h5555, 8'hAA, 3'd2, 32'hCAFE_F00D));
        // writes with no data
        send_command(make_command(ACTION_WRITE, 16'h2000, 8'h01, 3'd0, 32'hFFFF_FFFF));
        drain_frames();
    endtask

    task automatic test_register_extremes();
        write_register(CFG_NODE_ADDRESS, 16'h0000);
        write_register(CFG_COB_ID, 16'h0000);
        write_register(CFG_START_ADDRESS, 16'h0000);
        send_command(make_command(ACTION_READ, 16'h6064, 8'h00, 3'd0, 32'h0));
        send_command(make_command(ACTION_WRITE, 16'h60FF, 8'h00, 3'd4, 32'hFFFF_FC18));
        drain_frames();
        write_register(CFG_NODE_ADDRESS, 16'h00FF);
        write_register(CFG_COB_ID, 16'h00FF);
        write_register(CFG_START_ADDRESS, 16'hFFFF);
        send_command(make_command(ACTION_READ, 16'hFFFF, 8'hFF, 3'd0, 32'h0));
        send_command(make_command(ACTION_WRITE, 16'h0000, 8'h00, 3'd4, 32'h0000_0001));
        drain_frames();
        // upper write bits beyond an 8-bit register are dropped
        write_register(CFG_NODE_ADDRESS, 16'hA5C3);
        write_register(CFG_COB_ID, 16'h5A3C);
        write_register(CFG_START_ADDRESS, 16'h8001);
        // a write to an unmapped index changes nothing
        write_register(CFG_UNMAPPED, 16'hBEEF);
        send_command(make_command(ACTION_WRITE, 16'h6081, 8'h00, 3'd3, 32'h0012_3456));
        drain_frames();
    endtask

    task automatic test_random_traffic(input int send_pct, input int recv_pct);
        logic [15:0] pick;
        set_idle_mix(send_pct, recv_pct);
        // fresh register setting for this phase, extremes now and then
        pick = 16'($urandom);
        write_register(CFG_NODE_ADDRESS, pick[0] ? 16'($urandom_range(16'hFFFF))
                                                 : (pick[1] ? 16'h00FF : 16'h0000));
        write_register(CFG_COB_ID, pick[2] ? 16'($urandom_range(16'hFFFF))
                                           : (pick[3] ? 16'h00FF : 16'h0000));
        write_register(CFG_START_ADDRESS, pick[4] ? 16'($urandom_range(16'hFFFF))
                                                  : (pick[5] ? 16'hFFFF : 16'h0000));
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            send_command(random_command());
        end
        drain_frames();
    endtask

    task automatic test_output_holdoff();
        set_idle_mix(0, 0);
        hold_left <= HOLDOFF_LEN;
        // keep offering while the output is stuck so the input backs up
        for (int i = 0; i < 12; i++) begin
            send_command(random_command());
        end
        drain_frames();
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        set_idle_mix(0, 0);
        test_reset_values();
        test_field_extremes();
        test_register_extremes();
        test_output_holdoff();
        test_random_traffic(14, 80);
        test_random_traffic(80, 14);
        test_random_traffic(0, 0);

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (expected_frame_q.size() != 0) begin
            report_failure($sformatf("%0d frame bytes never arrived", expected_frame_q.size()));
        end
        $display("covered %0d commands, %0d frame bytes checked, %0d register writes",
                 commands_sent, bytes_checked, register_writes);
        $display("field corners, clamped sizes, register extremes, output hold-off, %s%0d",
                 "three idle mixes; failures: ", error_count);
        if (error_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

[sim.f]
+incdir+design
design/mcfb_pkg.sv
design/mcfb_ctrl.sv
design/mcfb_dp.sv
design/motor_command_frame_builder_core.sv
tb/testbench.sv
